// ===== design/tevheap_pkg.sv =====
// Shared types and constants for the timed event min-heap.
`timescale 1ns / 1ps
`default_nettype none

package tevheap_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdFieldW = 16;
  localparam int unsigned CountW   = 5;

  // Packed stream layouts.
  localparam int unsigned InDataW  = 80;  // event_time, event_id, now
  localparam int unsigned OutDataW = 56;  // fired_id, fired_time, entry_count, pad
  localparam int unsigned OutUserW = 2;   // fired, overflow

  // Bit positions inside the input tdata.
  localparam int unsigned InTimeLsb = 0;
  localparam int unsigned InIdLsb   = InTimeLsb + TimeW;
  localparam int unsigned InNowLsb  = InIdLsb + IdFieldW;

  // An entry more than this far ahead of now is taken as already past.
  localparam logic [TimeW-1:0] WrapLimit = 32'h8000_0000;

  // Item kind carried in the input tuser.
  typedef enum logic {
    KIND_ENQ  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_PLACE,
    ST_TK_CHK,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_PLACE,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ===== design/timed_event_min_heap_unit.sv =====
// Top level of the timed event min-heap: sequencer, sift datapath and result register.
//
//   Channel  Dir  tdata (low bit up)                          tuser
//   s_axis   in   event_time, event_id, now                   kind
//   m_axis   out  fired_id, fired_time, entry_count, 3'b0     fired, overflow
//
// One item is worked on at a time; as each heap level is walked, a parent or a
// child pair is read from the registered entry memory while the previous level is
// written back. An enqueue sifts up and a tick that pops sifts down, each over at
// most log2(DEPTH) heap levels; an overflow or a tick on an empty heap walks none,
// and neither does a tick whose root is not yet due.
// The next item can be taken in the cycle after a result is loaded.
// Reset clears the sequencer, the entry count and the result valid; the memory
// is not cleared. A stalled result waits in the output register while the next
// item is taken and worked on; that item then holds in its last state.
`timescale 1ns / 1ps
`default_nettype none

module timed_event_min_heap_unit #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // event_time[31:0], event_id[47:32], now[79:48]
  input  logic [tevheap_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fired_id[15:0], fired_time[47:16], entry_count[52:48], zero[55:53]
  output logic [tevheap_pkg::OutDataW-1:0]  m_axis_tdata,
  // fired[0], overflow[1]
  output logic [tevheap_pkg::OutUserW-1:0]  m_axis_tuser
);

  import tevheap_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned EW = TimeW + ID_BITS;

  typedef struct packed {
    logic [TimeW-1:0]   et;
    logic [ID_BITS-1:0] eid;
  } entry_t;

  // State registers.
  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pos_q, pos_d;
  entry_t             cur_q, cur_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic               res_fired_q, res_fired_d;
  logic               res_ovf_q, res_ovf_d;
  logic [TimeW-1:0]   res_time_q, res_time_d;
  logic [ID_BITS-1:0] res_id_q, res_id_d;
  logic               out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr0, mem_raddr1;
  entry_t        mem_wdata, mem_rdata0, mem_rdata1;

  // Input unpacking.
  logic               in_acc;
  logic [TimeW-1:0]   in_time, in_now;
  logic [31:0]        in_id_wide;
  entry_t             in_entry;
  kind_e              in_kind;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_time    = s_axis_tdata[InTimeLsb +: TimeW];
  assign in_now     = s_axis_tdata[InNowLsb +: TimeW];
  assign in_id_wide = {16'b0, s_axis_tdata[InIdLsb +: IdFieldW]};
  assign in_entry   = '{et: in_time, eid: in_id_wide[ID_BITS-1:0]};
  assign in_kind    = kind_e'(s_axis_tuser);

  // Entry memory.
  tevheap_store #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (mem_we),
    .wr_addr_i  (mem_waddr),
    .wr_data_i  (mem_wdata),
    .rd0_addr_i (mem_raddr0),
    .rd1_addr_i (mem_raddr1),
    .rd0_data_o (mem_rdata0),
    .rd1_data_o (mem_rdata1)
  );

  // Shared decisions.
  logic          heap_full, heap_empty, count_one;
  logic [CW-1:0] enq_pos, parent_pos;
  logic          parent_is_root, up_stop;
  logic          waiting;
  logic [TimeW-1:0] ahead;
  logic [LW-1:0] left_pos, count_ext, right_pos;
  logic          has_left, right_ok, left_wins, go_right, move_down;
  logic [TimeW-1:0] min_time;
  logic [CW-1:0] child_pos;
  entry_t        child_entry;
  logic [LW-1:0] next_left;
  logic          next_has_left;
  logic          out_free;

  assign heap_full      = (count_q == CW'(DEPTH));
  assign heap_empty     = (count_q == '0);
  assign count_one      = (count_q == CW'(1));
  assign enq_pos        = count_q + CW'(1);
  assign parent_pos     = pos_q >> 1;
  assign parent_is_root = (parent_pos == CW'(1));
  // The child moves up unless it is strictly later than its parent.
  assign up_stop        = (cur_q.et > mem_rdata0.et);

  // Due check on the root.
  assign ahead   = mem_rdata0.et - now_q;
  assign waiting = (now_q < mem_rdata0.et) && (ahead <= WrapLimit);

  // Sift-down child selection, left child kept on ties.
  assign left_pos      = {pos_q, 1'b0};
  assign count_ext     = {1'b0, count_q};
  assign right_pos     = left_pos + LW'(1);
  assign has_left      = (left_pos <= count_ext);
  assign right_ok      = (right_pos <= count_ext);
  assign left_wins     = (cur_q.et > mem_rdata0.et);
  assign min_time      = left_wins ? mem_rdata0.et : cur_q.et;
  assign go_right      = right_ok && (min_time > mem_rdata1.et);
  assign move_down     = left_wins || go_right;
  assign child_pos     = go_right ? right_pos[CW-1:0] : left_pos[CW-1:0];
  assign child_entry   = go_right ? mem_rdata1 : mem_rdata0;
  assign next_left     = {child_pos, 1'b0};
  assign next_has_left = (next_left <= count_ext);

  assign out_free = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_ENQ) begin
            if (heap_full) begin
              state_d = ST_FIN;
            end else if (heap_empty) begin
              state_d = ST_UP_PLACE;
            end else begin
              state_d = ST_UP_CMP;
            end
          end else if (heap_empty) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_TK_CHK;
          end
        end
      end
      ST_UP_CMP: begin
        if (up_stop) begin
          state_d = ST_FIN;
        end else if (parent_is_root) begin
          state_d = ST_UP_PLACE;
        end
      end
      ST_UP_PLACE: state_d = ST_FIN;
      ST_TK_CHK: begin
        if (waiting || count_one) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (has_left) begin
          state_d = ST_DN_CMP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DN_CMP: begin
        if (!move_down) begin
          state_d = ST_FIN;
        end else if (!next_has_left) begin
          state_d = ST_DN_PLACE;
        end
      end
      ST_DN_PLACE: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory ports and result staging.
  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    now_d       = now_q;
    res_fired_d = res_fired_q;
    res_ovf_d   = res_ovf_q;
    res_time_d  = res_time_q;
    res_id_d    = res_id_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(pos_q - CW'(1));
    mem_wdata   = cur_q;
    mem_raddr0  = '0;
    mem_raddr1  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d       = in_now;
          res_fired_d = 1'b0;
          res_ovf_d   = 1'b0;
          res_time_d  = '0;
          res_id_d    = '0;
          if (in_kind == KIND_ENQ) begin
            if (heap_full) begin
              res_ovf_d = 1'b1;
            end else begin
              // Open a slot at the end and fetch its parent.
              count_d    = enq_pos;
              pos_d      = enq_pos;
              cur_d      = in_entry;
              mem_raddr0 = AW'((enq_pos >> 1) - CW'(1));
            end
          end else if (!heap_empty) begin
            // Fetch root and last entry together.
            mem_raddr0 = '0;
            mem_raddr1 = AW'(count_q - CW'(1));
          end
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (!up_stop) begin
          // Parent drops into the hole; fetch the next parent up.
          mem_wdata  = mem_rdata0;
          pos_d      = parent_pos;
          mem_raddr0 = AW'((parent_pos >> 1) - CW'(1));
        end
      end
      ST_UP_PLACE: mem_we = 1'b1;
      ST_TK_CHK: begin
        if (!waiting) begin
          res_fired_d = 1'b1;
          res_time_d  = mem_rdata0.et;
          res_id_d    = mem_rdata0.eid;
          count_d     = count_q - CW'(1);
          cur_d       = mem_rdata1;
          pos_d       = CW'(1);
        end
      end
      ST_DN_RD: begin
        if (has_left) begin
          mem_raddr0 = AW'(left_pos - LW'(1));
          mem_raddr1 = AW'(left_pos);
        end else begin
          mem_we = 1'b1;
        end
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (move_down) begin
          // Smaller child rises into the hole; fetch its children.
          mem_wdata  = child_entry;
          pos_d      = child_pos;
          mem_raddr0 = AW'(next_left - LW'(1));
          mem_raddr1 = AW'(next_left);
        end
      end
      ST_DN_PLACE: mem_we = 1'b1;
      ST_FIN: ;
      default: ;
    endcase
  end

  // Result register.
  logic [31:0] count_wide;
  logic [31:0] res_id_wide;

  assign count_wide  = 32'(count_q);
  assign res_id_wide = 32'(res_id_q);

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, count_wide[CountW-1:0], res_time_q, res_id_wide[IdFieldW-1:0]};
      out_user_d  = {res_ovf_q, res_fired_q};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    now_q       <= now_d;
    res_fired_q <= res_fired_d;
    res_ovf_q   <= res_ovf_d;
    res_time_q  <= res_time_d;
    res_id_q    <= res_id_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_write_in_heap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (pos_q != '0) && (pos_q <= count_q))
    else $error("entry write outside the held entries");

  a_fire_xor_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result both fired and overflowed");

  a_fin_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_free |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("finished item not loaded into the result register");

endmodule

`default_nettype wire

// ===== design/tevheap_store.sv =====
// Heap entry memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module tevheap_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd0_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rd1_addr_i,
  output logic [WIDTH-1:0]         rd0_data_o,
  output logic [WIDTH-1:0]         rd1_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Both read ports are registered: data comes back in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rd0_data_o <= mem_q[rd0_addr_i];
    rd1_data_o <= mem_q[rd1_addr_i];
  end

endmodule

`default_nettype wire
